### hw/rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// Timer expiry scheduler package
// Shared constants, payload structs and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int TIMER_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TIME_W      = 32;
  localparam int ENTRY_W     = TIME_W + 1;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [3:0]        timer_index;
    logic [TIME_W-1:0] now_ticks;
    logic [TIME_W-1:0] mark_ticks;
    logic [TIME_W-1:0] timeout_ticks;
  } tes_in_t;

  typedef struct packed {
    logic [3:0] expired_index;
    logic       last_of_run;
  } tes_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_PICK,
    S_FLUSH
  } tes_state_t;

endpackage

`default_nettype wire

### hw/rtl/tes_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/timer_expiry_scheduler_core.sv
// Start and stop transactions need no scan; a start that fires at once adds one result.
// A tick scans the timer RAM once per expiry plus one final scan.
// A tick after a time wrap adds the scans that drain the whole current list.
// A new transaction is taken only in the idle state, so each tick holds the input until its
// scans and results are done; result stalls add to this.
// Reset clears the armed bits, current list and previous time at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// Timer expiry scheduler core
// Keeps expiry times and list membership in a RAM and reports expiries in
// ascending expiry order by repeated minimum scans over the timer slots.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_expiry_scheduler_core
  import tes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tes_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output tes_out_t      out_data
);

  tes_state_t              state_r, state_nxt;
  logic [NUM_TIMERS-1:0]   armed_r, armed_nxt;
  logic                    cur_list_r, cur_list_nxt;
  logic [TIME_W-1:0]       prev_now_r, prev_now_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic                    phase_all_r, phase_all_nxt;
  logic [TIMER_IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic                    cmp_v_r, cmp_v_nxt;
  logic [TIMER_IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic                    best_found_r, best_found_nxt;
  logic [TIMER_IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0]       best_t_r, best_t_nxt;
  logic                    hold_v_r, hold_v_nxt;
  logic [TIMER_IDX_W-1:0]  hold_idx_r, hold_idx_nxt;
  logic                    out_v_r, out_v_nxt;
  tes_out_t                out_data_r, out_data_nxt;

  logic                    ram_we;
  logic [TIMER_IDX_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic                    in_acc;
  logic                    out_free;
  logic [TIMER_IDX_W-1:0]  in_idx;
  logic                    in_idx_ok;
  logic [TIME_W-1:0]       next_t;
  logic [TIME_W-1:0]       elapsed;
  logic                    fire;
  logic                    arm_list;
  logic [TIME_W-1:0]       rd_exp;
  logic                    rd_lst;
  logic                    cand;

  tes_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_TIMERS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx_r),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_v_r || !out_stall;

  assign in_idx    = TIMER_IDX_W'(in_data.timer_index);
  assign in_idx_ok = {5'd0, in_data.timer_index} < 9'(NUM_TIMERS);
  assign next_t    = in_data.mark_ticks + in_data.timeout_ticks;
  assign elapsed   = in_data.now_ticks - in_data.mark_ticks;

  always_comb begin
    fire     = 1'b0;
    arm_list = cur_list_r;
    if (next_t <= in_data.now_ticks) begin
      if (elapsed >= in_data.timeout_ticks) begin
        fire = 1'b1;
      end else begin
        arm_list = !cur_list_r;
      end
    end else if ((in_data.now_ticks < in_data.mark_ticks) &&
                 (next_t >= in_data.mark_ticks)) begin
      fire = 1'b1;
    end
  end

  assign rd_exp = ram_rdata[TIME_W-1:0];
  assign rd_lst = ram_rdata[TIME_W];
  assign cand   = cmp_v_r && armed_r[cmp_idx_r] && (rd_lst == cur_list_r) &&
                  (phase_all_r || (rd_exp <= now_r));

  always_comb begin
    state_nxt      = state_r;
    armed_nxt      = armed_r;
    cur_list_nxt   = cur_list_r;
    prev_now_nxt   = prev_now_r;
    now_nxt        = now_r;
    phase_all_nxt  = phase_all_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_v_nxt      = 1'b0;
    cmp_idx_nxt    = scan_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_t_nxt     = best_t_r;
    hold_v_nxt     = hold_v_r;
    hold_idx_nxt   = hold_idx_r;
    out_v_nxt      = out_v_r && out_stall;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = in_idx;
    ram_wdata      = {arm_list, next_t};

    if (cand && (!best_found_r || (rd_exp < best_t_r))) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = cmp_idx_r;
      best_t_nxt     = rd_exp;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.opcode)
            OP_TICK: begin
              phase_all_nxt  = (in_data.now_ticks < prev_now_r);
              prev_now_nxt   = in_data.now_ticks;
              now_nxt        = in_data.now_ticks;
              scan_idx_nxt   = '0;
              best_found_nxt = 1'b0;
              hold_v_nxt     = 1'b0;
              state_nxt      = S_SCAN;
            end
            OP_START: begin
              if (in_idx_ok) begin
                ram_we            = 1'b1;
                armed_nxt[in_idx] = !fire;
                if (fire) begin
                  hold_v_nxt   = 1'b1;
                  hold_idx_nxt = in_idx;
                  state_nxt    = S_FLUSH;
                end
              end
            end
            OP_STOP: begin
              if (in_idx_ok) begin
                armed_nxt[in_idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cmp_v_nxt    = 1'b1;
        cmp_idx_nxt  = scan_idx_r;
        scan_idx_nxt = scan_idx_r + 1'b1;
        if (scan_idx_r == TIMER_IDX_W'(NUM_TIMERS - 1)) begin
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (best_found_r) begin
          if (!hold_v_r || out_free) begin
            if (hold_v_r) begin
              out_v_nxt                  = 1'b1;
              out_data_nxt.expired_index = 4'(hold_idx_r);
              out_data_nxt.last_of_run   = 1'b0;
            end
            armed_nxt[best_idx_r] = 1'b0;
            hold_v_nxt            = 1'b1;
            hold_idx_nxt          = best_idx_r;
            best_found_nxt        = 1'b0;
            scan_idx_nxt          = '0;
            state_nxt             = S_SCAN;
          end
        end else if (phase_all_r) begin
          phase_all_nxt = 1'b0;
          cur_list_nxt  = !cur_list_r;
          scan_idx_nxt  = '0;
          state_nxt     = S_SCAN;
        end else if (hold_v_r) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_v_nxt                  = 1'b1;
          out_data_nxt.expired_index = 4'(hold_idx_r);
          out_data_nxt.last_of_run   = 1'b1;
          hold_v_nxt                 = 1'b0;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      armed_r      <= '0;
      cur_list_r   <= 1'b0;
      prev_now_r   <= '0;
      phase_all_r  <= 1'b0;
      scan_idx_r   <= '0;
      cmp_v_r      <= 1'b0;
      best_found_r <= 1'b0;
      hold_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      armed_r      <= armed_nxt;
      cur_list_r   <= cur_list_nxt;
      prev_now_r   <= prev_now_nxt;
      phase_all_r  <= phase_all_nxt;
      scan_idx_r   <= scan_idx_nxt;
      cmp_v_r      <= cmp_v_nxt;
      best_found_r <= best_found_nxt;
      hold_v_r     <= hold_v_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_t_r   <= best_t_nxt;
    hold_idx_r <= hold_idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/tes_checker.sv
// ----------------------------------------------------------------------------
// Timer expiry scheduler checker
// Port-level assertions on the scheduler core, attached by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_checker
  import tes_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    in_valid,
  input wire logic    in_stall,
  input wire tes_in_t in_data,
  input wire logic    out_valid,
  input wire logic    out_stall,
  input wire tes_out_t out_data
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A stop transaction leaves the input unstalled in the following cycle.
  a_stop_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == OP_STOP) |=> !in_stall)
    else $error("stop transaction did not complete at once");

  // A tick transaction always starts a scan of the timer slots.
  a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == OP_TICK) |=> in_stall)
    else $error("tick transaction did not start a scan");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind timer_expiry_scheduler_core tes_checker u_tes_checker (.*);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Timer expiry scheduler testbench
// A directed table of tick, start, stop and unused-opcode transactions comes
// first, then constrained-looking random traffic that walks a tick counter
// through wraps. Expiries are checked against an in-bench model (a fixed index
// for typed directed rows), with random input gaps and random result stalls.
// ----------------------------------------------------------------------------
module testbench;
  import tes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 135;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    tes_in_t    item;
    bit         typed;
    int         n_typed;
    logic [3:0] typed_index;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  tes_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  tes_out_t out_data;

  // Scheduler model state.
  logic [TIME_W-1:0] sched_expiry [NUM_TIMERS];
  logic              sched_armed  [NUM_TIMERS];
  logic              sched_list   [NUM_TIMERS];
  logic              sched_cur;
  logic [TIME_W-1:0] sched_prev_now;

  tes_out_t step_expiries[$];
  tes_out_t pending_expiries[$];
  tes_out_t want;
  dir_row_t dir_rows[$];

  int  errors = 0;
  int  checked = 0;
  int  n_ticks = 0;
  int  n_starts = 0;
  int  n_stops = 0;
  int  n_wraps = 0;
  int  max_burst = 0;
  bit  quiet_tx = 1'b0;
  bit  quiet_rx = 1'b0;

  timer_expiry_scheduler_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expires armed timers of one list, only the due ones when only_due is set,
  // in ascending expiry order, ties to the lower index.
  function automatic void expire_list(input logic lst, input logic only_due,
                                      input logic [TIME_W-1:0] now);
    int                best;
    logic [TIME_W-1:0] best_t;
    tes_out_t          r;
    do begin
      best = -1;
      best_t = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (sched_armed[i] && sched_list[i] == lst &&
            !(only_due && sched_expiry[i] > now)) begin
          if (best < 0 || sched_expiry[i] < best_t) begin
            best = i;
            best_t = sched_expiry[i];
          end
        end
      end
      if (best >= 0) begin
        sched_armed[best] = 1'b0;
        r.expired_index = 4'(best);
        r.last_of_run = 1'b0;
        step_expiries.push_back(r);
      end
    end while (best >= 0);
  endfunction

  function automatic void predict_expiries(input tes_in_t it);
    logic [TIME_W-1:0] next_t;
    logic              fire;
    tes_out_t          r;
    step_expiries.delete();
    fire = 1'b0;
    next_t = it.mark_ticks + it.timeout_ticks;
    case (it.opcode)
      OP_TICK: begin
        if (it.now_ticks < sched_prev_now) begin
          expire_list(sched_cur, 1'b0, it.now_ticks);
          sched_cur = ~sched_cur;
          n_wraps++;
        end
        sched_prev_now = it.now_ticks;
        expire_list(sched_cur, 1'b1, it.now_ticks);
      end
      OP_START, OP_STOP: begin
        if (it.timer_index < NUM_TIMERS) begin
          sched_armed[it.timer_index] = 1'b0;
          if (it.opcode == OP_START) begin
            sched_expiry[it.timer_index] = next_t;
            if (next_t <= it.now_ticks) begin
              if ((it.now_ticks - it.mark_ticks) >= it.timeout_ticks) begin
                fire = 1'b1;
              end else begin
                sched_armed[it.timer_index] = 1'b1;
                sched_list[it.timer_index] = ~sched_cur;
              end
            end else if (it.now_ticks < it.mark_ticks && next_t >= it.mark_ticks) begin
              fire = 1'b1;
            end else begin
              sched_armed[it.timer_index] = 1'b1;
              sched_list[it.timer_index] = sched_cur;
            end
            if (fire) begin
              r.expired_index = it.timer_index;
              r.last_of_run = 1'b0;
              step_expiries.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
    if (step_expiries.size() > 0) begin
      r = step_expiries[step_expiries.size()-1];
      r.last_of_run = 1'b1;
      step_expiries[step_expiries.size()-1] = r;
    end
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [3:0] idx,
                                  input logic [TIME_W-1:0] now,
                                  input logic [TIME_W-1:0] mark,
                                  input logic [TIME_W-1:0] tmo, input bit typed,
                                  input int n, input logic [3:0] eidx);
    dir_row_t row;
    row.item.opcode = op;
    row.item.timer_index = idx;
    row.item.now_ticks = now;
    row.item.mark_ticks = mark;
    row.item.timeout_ticks = tmo;
    row.typed = typed;
    row.n_typed = n;
    row.typed_index = eidx;
    dir_rows.push_back(row);
  endfunction

  task automatic send_item(input tes_in_t it, input bit typed, input int n_typed,
                           input logic [3:0] typed_index);
    int       gap;
    tes_out_t r;
    gap = quiet_tx ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_expiries(it);
    case (it.opcode)
      OP_TICK: n_ticks++;
      OP_START: n_starts++;
      OP_STOP: n_stops++;
      default: ;
    endcase
    if (step_expiries.size() > max_burst) max_burst = step_expiries.size();
    if (typed) begin
      if (n_typed > 0) begin
        r.expired_index = typed_index;
        r.last_of_run = 1'b1;
        pending_expiries.push_back(r);
      end
    end else begin
      foreach (step_expiries[j]) pending_expiries.push_back(step_expiries[j]);
    end
  endtask

  // Result side: a random stall, none while quiet_rx is set, before each transaction.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = quiet_rx ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_expiries.size() == 0) begin
        $display("%0t: unexpected expiry, expected none, got index %0d last %0b",
                 $time, out_data.expired_index, out_data.last_of_run);
        errors++;
      end else begin
        want = pending_expiries.pop_front();
        if (out_data.expired_index !== want.expired_index ||
            out_data.last_of_run !== want.last_of_run) begin
          $display("%0t: expiry mismatch, expected index %0d last %0b, got index %0d last %0b",
                   $time, want.expired_index, want.last_of_run,
                   out_data.expired_index, out_data.last_of_run);
          errors++;
        end
        checked++;
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    tes_in_t           it;
    logic [TIME_W-1:0] sim_now;
    int                real_items;
    int                sel;
    int                pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      sched_armed[i] = 1'b0;
      sched_list[i] = 1'b0;
      sched_expiry[i] = '0;
    end
    sched_cur = 1'b0;
    sched_prev_now = '0;

    add_row(OP_TICK,   4'd0,  32'd0,          32'd0,          32'd0,          1, 0, 4'd0);
    add_row(OP_START,  4'd0,  32'd0,          32'd0,          32'd0,          1, 1, 4'd0);
    add_row(OP_START,  4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  0, 0, 4'd0);
    add_row(OP_START,  4'd1,  32'd100,        32'd100,        32'd50,         0, 0, 4'd0);
    add_row(OP_START,  4'd3,  32'd10,         32'd200,        32'd5,          1, 1, 4'd3);
    add_row(OP_START,  4'd4,  32'h0000_0100,  32'hFFFF_FFF0,  32'h0000_0020,  1, 1, 4'd4);
    add_row(OP_START,  4'd5,  32'd110,        32'd100,        32'd20,         0, 0, 4'd0);
    add_row(OP_START,  4'd6,  32'd110,        32'd100,        32'd20,         0, 0, 4'd0);
    add_row(OP_START,  4'd7,  32'd110,        32'd105,        32'd10,         0, 0, 4'd0);
    add_row(OP_START,  4'd8,  32'd110,        32'd110,        32'hFFFF_FFFF,  0, 0, 4'd0);
    add_row(OP_TICK,   4'd0,  32'd120,        32'd0,          32'd0,          0, 0, 4'd0);
    add_row(OP_START,  4'd5,  32'd120,        32'd120,        32'd1000,       0, 0, 4'd0);
    add_row(OP_START,  4'd5,  32'd120,        32'd120,        32'd30,         0, 0, 4'd0);
    add_row(OP_TICK,   4'd0,  32'd150,        32'd0,          32'd0,          0, 0, 4'd0);
    add_row(OP_STOP,   4'd8,  32'd150,        32'd0,          32'd0,          1, 0, 4'd0);
    add_row(OP_STOP,   4'd9,  32'd150,        32'd0,          32'd0,          1, 0, 4'd0);
    add_row(OP_UNUSED, 4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1, 0, 4'd0);
    add_row(OP_START,  4'd2,  32'd200,        32'd200,        32'd100,        0, 0, 4'd0);
    add_row(OP_START,  4'd10, 32'd200,        32'd200,        32'h7FFF_FFFF,  0, 0, 4'd0);
    add_row(OP_TICK,   4'd0,  32'd5,          32'd0,          32'd0,          0, 0, 4'd0);
    add_row(OP_TICK,   4'd0,  32'hFFFF_FFFF,  32'd0,          32'd0,          1, 1, 4'd15);
    add_row(OP_TICK,   4'd0,  32'hFFFF_FFFF,  32'd0,          32'd0,          1, 0, 4'd0);
    add_row(OP_TICK,   4'd0,  32'd0,          32'd0,          32'd0,          1, 0, 4'd0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].n_typed,
                dir_rows[k].typed_index);
    end

    sim_now = 32'd1000;
    real_items = 0;
    while (real_items < RAND_ITEMS) begin
      if (real_items % 40 == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
      end
      it = '0;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        it.opcode = OP_START;
        it.timer_index = 4'($urandom_range(0, NUM_TIMERS - 1));
        it.now_ticks = sim_now;
        it.mark_ticks = sim_now - $urandom_range(0, 8);
        pick = $urandom_range(0, 19);
        if (pick == 0) it.timeout_ticks = '0;
        else if (pick == 1) it.timeout_ticks = $urandom;
        else it.timeout_ticks = $urandom_range(0, 300);
      end else if (sel < 78) begin
        if ($urandom_range(0, 11) == 0) sim_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
        else sim_now = sim_now + $urandom_range(0, 120);
        it.opcode = OP_TICK;
        it.now_ticks = sim_now;
      end else if (sel < 88) begin
        it.opcode = OP_STOP;
        it.timer_index = 4'($urandom_range(0, NUM_TIMERS - 1));
        it.now_ticks = sim_now;
      end else begin
        it.opcode = 2'($urandom_range(0, 3));
        it.timer_index = 4'($urandom_range(0, 15));
        it.now_ticks = $urandom;
        it.mark_ticks = $urandom;
        it.timeout_ticks = $urandom;
      end
      send_item(it, 1'b0, 0, 4'd0);
      if (it.opcode != OP_UNUSED) real_items++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_expiries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions: %0d ticks, %0d starts, %0d stops.",
             n_ticks + n_starts + n_stops, n_ticks, n_starts, n_stops);
    $display("Checked %0d expiries over %0d counter wraps, up to %0d from one transaction.",
             checked, n_wraps, max_burst);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/tes_pkg.sv
hw/rtl/tes_ram.sv
hw/rtl/timer_expiry_scheduler_core.sv
hw/rtl/tes_checker.sv
tb/testbench.sv
